// ===== rtl/crk_pkg.sv =====
`timescale 1ns / 1ps

package crk_pkg;

  // Build constants
  localparam int MAX_SEG      = 16;
  localparam int CHANNEL_BITS = 24;
  localparam int NCH          = 10;
  localparam int FRAME_W      = 16;
  localparam int PORT_W       = 24;

  // Derived widths
  localparam int SEG_W  = $clog2(MAX_SEG + 1);
  localparam int CJ_W   = $clog2(NCH);
  localparam int MA_W   = 34;
  localparam int MB_W   = 19;
  localparam int PROD_W = MA_W + MB_W;
  localparam int ACC_W  = PROD_W + 2;

  // One keyframe as it arrives on the input channel.
  typedef struct packed {
    logic [FRAME_W-1:0]       key_frame;
    logic signed [PORT_W-1:0] scale_x;
    logic signed [PORT_W-1:0] scale_y;
    logic signed [PORT_W-1:0] scale_z;
    logic signed [PORT_W-1:0] quat_w;
    logic signed [PORT_W-1:0] quat_x;
    logic signed [PORT_W-1:0] quat_y;
    logic signed [PORT_W-1:0] quat_z;
    logic signed [PORT_W-1:0] move_x;
    logic signed [PORT_W-1:0] move_y;
    logic signed [PORT_W-1:0] move_z;
    logic                     is_final;
  } key_in_t;

  // One generated frame on the result channel.
  typedef struct packed {
    logic [FRAME_W-1:0]       frame_number;
    logic signed [PORT_W-1:0] out_scale_x;
    logic signed [PORT_W-1:0] out_scale_y;
    logic signed [PORT_W-1:0] out_scale_z;
    logic signed [PORT_W-1:0] out_quat_w;
    logic signed [PORT_W-1:0] out_quat_x;
    logic signed [PORT_W-1:0] out_quat_y;
    logic signed [PORT_W-1:0] out_quat_z;
    logic signed [PORT_W-1:0] out_move_x;
    logic signed [PORT_W-1:0] out_move_y;
    logic signed [PORT_W-1:0] out_move_z;
    logic                     last_of_run;
  } frame_out_t;

  // Stored keyframe: frame number and channels at internal width.
  typedef struct packed {
    logic [FRAME_W-1:0]                   frame;
    logic [NCH-1:0][CHANNEL_BITS-1:0]     ch;
  } key_rec_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CHECK,
    ST_DIV,
    ST_WGT,
    ST_CHAN,
    ST_DRAIN,
    ST_EMIT,
    ST_SEG_NEXT,
    ST_END
  } state_t;

endpackage

// ===== rtl/crk_if.sv =====
`timescale 1ns / 1ps

// Keyframe channel.
interface crk_key_if import crk_pkg::*; ();
  logic    valid;
  logic    ready;
  key_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Generated frame channel.
interface crk_frame_if import crk_pkg::*; ();
  logic       valid;
  logic       ready;
  frame_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/catmull_rom_keyframe_interp.sv =====
`timescale 1ns / 1ps

// Channel     Dir  Handshake            Payload
// in_key      in   valid/ready          key_in_t: frame number, ten channels, is_final
// out_frame   out  valid/ready          frame_out_t: frame number, ten channels, last_of_run
// cfg         in   cfg_we               cfg_wdata: total_frames
//
// For each keyframe, each segment loads its four keys, checks the gap and then forms
// the bit-serial reciprocal of the gap. Each frame then runs on the one shared 34x19
// multiplier: 5 products for the basis weights, forming the weights, 40 channel
// products, and then accumulating and rounding the last channel.
// The block takes no keyframe while it works on one; a stalled result holds the
// sequencer before the next frame is loaded into the output register.
// Reset is synchronous and clears the state, the window count, total_frames and the output valid.

module catmull_rom_keyframe_interp import crk_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  crk_key_if.sink     in_key,
  crk_frame_if.source out_frame,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  // Convert a port channel to internal width.
  function automatic logic [CHANNEL_BITS-1:0] to_ch(logic [PORT_W-1:0] f);
    return CHANNEL_BITS'(f);
  endfunction

  // Round to Q12.12, ties up, and saturate to the channel width.
  function automatic logic [PORT_W-1:0] rnd_sat(logic signed [ACC_W-1:0] s);
    logic signed [ACC_W-1:0] t;
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    logic [CHANNEL_BITS-1:0] c;
    t  = s + $signed(ACC_W'(65536));
    t  = t >>> 17;
    hi = $signed({{(ACC_W-CHANNEL_BITS+1){1'b0}}, {(CHANNEL_BITS-1){1'b1}}});
    lo = ~hi;
    if (t > hi) begin
      c = hi[CHANNEL_BITS-1:0];
    end else if (t < lo) begin
      c = lo[CHANNEL_BITS-1:0];
    end else begin
      c = t[CHANNEL_BITS-1:0];
    end
    return PORT_W'(c);
  endfunction

  state_t state_r, state_nxt;

  logic [1:0]  keys_r;
  logic [15:0] tot_r;
  key_rec_t    seq_r [5];
  key_rec_t    kk_r [4];
  logic        fin_r;
  logic [1:0]  w_r;
  logic [2:0]  mlast_r;
  logic [2:0]  seg_r;
  logic [2:0]  last_r;
  logic [1:0]  ld_cnt_r;

  logic [15:0]      g_r;
  logic [SEG_W-1:0] n_r;
  logic [SEG_W-1:0] i_r;
  logic [15:0]      rem_r;
  logic [16:0]      q_r;
  logic [4:0]       dcnt_r;
  logic [16:0]      u_r;
  logic [15:0]      ur_r;
  logic [2:0]       step_r;

  logic signed [PROD_W-1:0] prod_r;
  logic [31:0]              u2_r;
  logic [16:0]              h00_r, h01_r, h10_r, h11_r;
  logic signed [MB_W-1:0]   coef_r [4];

  logic [CJ_W-1:0] chj_r;
  logic [1:0]      cht_r;
  logic            tag_vld_r;
  logic [CJ_W-1:0] tag_j_r;
  logic [1:0]      tag_t_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [PORT_W-1:0] res_r [NCH];

  logic       out_vld_r;
  frame_out_t out_data_r;

  // Control decode
  logic                   in_rdy;
  logic                   in_acc;
  logic                   out_free;
  logic signed [MA_W-1:0] ma;
  logic signed [MB_W-1:0] mb;
  logic signed [PROD_W-1:0] prod_nxt;
  logic [2:0]             rd_idx;
  logic                   has_seg;
  logic                   gap_pos;
  logic                   div_ge;
  logic [16:0]            div_rs;
  logic                   frame_end;
  logic                   later_ne;
  logic [3:0]             ne;
  logic [15:0]            u16;
  logic [16:0]            v17;
  logic [17:0]            w3;
  logic [16:0]            ur_sum;
  logic                   ur_ge;
  logic signed [ACC_W-1:0] acc_sum;
  logic [50:0]            rnd01, rnd00, rnd_p;
  key_rec_t               new_rec;
  key_rec_t               tail_rec;

  assign in_acc = in_key.valid && in_rdy;
  assign in_key.ready = in_rdy;
  assign out_frame.valid = out_vld_r;
  assign out_frame.data = out_data_r;
  assign out_free = !out_vld_r || out_frame.ready;

  assign has_seg   = in_key.data.is_final || (keys_r >= 2'd2);
  assign gap_pos   = kk_r[2].frame > kk_r[1].frame;
  assign frame_end = (i_r == n_r - SEG_W'(1));
  assign div_rs    = {rem_r, (dcnt_r == 5'd0)};
  assign div_ge    = div_rs >= {1'b0, g_r};
  assign u16       = u_r[15:0];
  assign v17       = 17'(18'd65536 - 18'(u16));
  assign w3        = 18'(19'd196608 - {2'b0, u16, 1'b0});
  assign ur_sum    = 17'(ur_r) + 17'(rem_r);
  assign ur_ge     = ur_sum >= 17'(g_r);
  assign rnd_p     = 51'(prod_r[49:0]) + (51'(1) << 31);
  assign rnd01     = rnd_p;
  assign rnd00     = (51'(1) << 48) - 51'(prod_r[49:0]) + (51'(1) << 31);
  assign prod_nxt  = ma * mb;
  assign acc_sum   = ((tag_t_r == 2'd0) ? '0 : acc_r) + ACC_W'(prod_r);

  // Incoming key at internal width, and its copy at total_frames for the flush.
  always_comb begin
    new_rec.frame = in_key.data.key_frame;
    new_rec.ch[0] = to_ch(in_key.data.scale_x);
    new_rec.ch[1] = to_ch(in_key.data.scale_y);
    new_rec.ch[2] = to_ch(in_key.data.scale_z);
    new_rec.ch[3] = to_ch(in_key.data.quat_w);
    new_rec.ch[4] = to_ch(in_key.data.quat_x);
    new_rec.ch[5] = to_ch(in_key.data.quat_y);
    new_rec.ch[6] = to_ch(in_key.data.quat_z);
    new_rec.ch[7] = to_ch(in_key.data.move_x);
    new_rec.ch[8] = to_ch(in_key.data.move_y);
    new_rec.ch[9] = to_ch(in_key.data.move_z);
    tail_rec       = new_rec;
    tail_rec.frame = tot_r;
  end

  // Whether any later segment of this keyframe will produce a frame.
  always_comb begin
    later_ne = 1'b0;
    for (int k = 0; k < 4; k++) begin
      ne[k] = seq_r[k+1].frame > seq_r[k].frame;
      if ((3'(k) > seg_r) && (3'(k) <= last_r) && ne[k]) begin
        later_ne = 1'b1;
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = has_seg ? ST_LOAD : ST_END;
        end
      end
      ST_LOAD: begin
        if (ld_cnt_r == 2'd3) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK:    state_nxt = gap_pos ? ST_DIV : ST_SEG_NEXT;
      ST_DIV: begin
        if (dcnt_r == 5'd16) begin
          state_nxt = ST_WGT;
        end
      end
      ST_WGT: begin
        if (step_r == 3'd6) begin
          state_nxt = ST_CHAN;
        end
      end
      ST_CHAN: begin
        if ((chj_r == CJ_W'(NCH - 1)) && (cht_r == 2'd3)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN:    state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = frame_end ? ST_SEG_NEXT : ST_WGT;
        end
      end
      ST_SEG_NEXT: state_nxt = (seg_r == last_r) ? ST_END : ST_LOAD;
      ST_END:      state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs: ready, key read index and multiplier operands.
  always_comb begin
    in_rdy = 1'b0;
    ma     = '0;
    mb     = '0;
    case (ld_cnt_r)
      2'd0:    rd_idx = (seg_r == 3'd0) ? 3'd0 : seg_r - 3'd1;
      2'd1:    rd_idx = seg_r;
      2'd2:    rd_idx = seg_r + 3'd1;
      default: rd_idx = ((seg_r + 3'd2) > mlast_r) ? mlast_r : seg_r + 3'd2;
    endcase
    case (state_r)
      ST_IDLE: in_rdy = 1'b1;
      ST_WGT: begin
        case (step_r)
          3'd0: begin
            ma = $signed(MA_W'(u16));
            mb = $signed(MB_W'(u16));
          end
          3'd1: begin
            ma = $signed(MA_W'(prod_r[31:0]));
            mb = $signed(MB_W'(w3));
          end
          3'd2: begin
            ma = $signed(MA_W'(u2_r));
            mb = $signed(MB_W'(v17));
          end
          3'd3: begin
            ma = $signed(MA_W'(u16));
            mb = $signed(MB_W'(v17));
          end
          3'd4: begin
            ma = $signed(MA_W'(prod_r[31:0]));
            mb = $signed(MB_W'(v17));
          end
          default: begin
            ma = '0;
            mb = '0;
          end
        endcase
      end
      ST_CHAN: begin
        ma = MA_W'($signed(kk_r[cht_r].ch[chj_r]));
        mb = coef_r[cht_r];
      end
      default: begin
        in_rdy = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      keys_r    <= 2'd0;
      tot_r     <= 16'd0;
      out_vld_r <= 1'b0;
      tag_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      tag_vld_r <= (state_r == ST_CHAN);
      if (cfg_we) begin
        tot_r <= cfg_wdata;
      end
      if (state_r == ST_EMIT && out_free) begin
        out_vld_r <= 1'b1;
      end else if (out_frame.ready) begin
        out_vld_r <= 1'b0;
      end
      if (state_r == ST_END) begin
        if (fin_r) begin
          keys_r <= 2'd0;
        end else if (w_r == 2'd3) begin
          keys_r <= 2'd3;
        end else begin
          keys_r <= w_r + 2'd1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    tag_j_r <= chj_r;
    tag_t_r <= cht_r;

    // Key capture and segment schedule.
    if (in_acc) begin
      seq_r[3'(keys_r)] <= new_rec;
      if (in_key.data.is_final) begin
        seq_r[3'(keys_r) + 3'd1] <= tail_rec;
      end
      fin_r    <= in_key.data.is_final;
      w_r      <= keys_r;
      mlast_r  <= in_key.data.is_final ? 3'(keys_r) + 3'd1 : 3'(keys_r);
      last_r   <= in_key.data.is_final ? 3'(keys_r) : 3'(keys_r) - 3'd2;
      seg_r    <= (keys_r >= 2'd2) ? 3'(keys_r) - 3'd2 : 3'd0;
      ld_cnt_r <= 2'd0;
    end

    // Four keys of the segment, one per cycle.
    if (state_r == ST_LOAD) begin
      kk_r[ld_cnt_r] <= seq_r[rd_idx];
      ld_cnt_r       <= ld_cnt_r + 2'd1;
    end

    // Gap and frame count.
    if (state_r == ST_CHECK) begin
      g_r    <= kk_r[2].frame - kk_r[1].frame;
      n_r    <= ((kk_r[2].frame - kk_r[1].frame) > 16'(MAX_SEG)) ? SEG_W'(MAX_SEG)
                : SEG_W'(kk_r[2].frame - kk_r[1].frame);
      rem_r  <= 16'd0;
      q_r    <= 17'd0;
      dcnt_r <= 5'd0;
    end

    // Restoring division of 2^16 by the gap, one quotient bit a cycle.
    if (state_r == ST_DIV) begin
      rem_r  <= div_ge ? 16'(div_rs - {1'b0, g_r}) : div_rs[15:0];
      q_r    <= {q_r[15:0], div_ge};
      dcnt_r <= dcnt_r + 5'd1;
      u_r    <= 17'd0;
      ur_r   <= 16'd0;
      i_r    <= '0;
      step_r <= 3'd0;
    end

    // Basis weight sequence.
    if (state_r == ST_WGT) begin
      step_r <= step_r + 3'd1;
      case (step_r)
        3'd1: u2_r <= prod_r[31:0];
        3'd2: begin
          h01_r <= rnd01[48:32];
          h00_r <= rnd00[48:32];
        end
        3'd3: h11_r <= rnd_p[48:32];
        3'd5: h10_r <= rnd_p[48:32];
        3'd6: begin
          coef_r[0] <= -$signed(MB_W'(h10_r));
          coef_r[1] <= $signed(MB_W'({h00_r, 1'b0}) + MB_W'(h11_r));
          coef_r[2] <= $signed(MB_W'({h01_r, 1'b0}) + MB_W'(h10_r));
          coef_r[3] <= -$signed(MB_W'(h11_r));
          chj_r     <= '0;
          cht_r     <= 2'd0;
        end
        default: begin
        end
      endcase
    end

    // Channel product issue.
    if (state_r == ST_CHAN) begin
      cht_r <= cht_r + 2'd1;
      if (cht_r == 2'd3) begin
        chj_r <= chj_r + CJ_W'(1);
      end
    end

    // Accumulate one product behind the issue.
    if (tag_vld_r) begin
      acc_r <= acc_sum;
      if (tag_t_r == 2'd3) begin
        res_r[tag_j_r] <= rnd_sat(acc_sum);
      end
    end

    // Load the output register and step u by the reciprocal.
    if (state_r == ST_EMIT && out_free) begin
      out_data_r.frame_number <= kk_r[1].frame + FRAME_W'(i_r);
      out_data_r.out_scale_x  <= res_r[0];
      out_data_r.out_scale_y  <= res_r[1];
      out_data_r.out_scale_z  <= res_r[2];
      out_data_r.out_quat_w   <= res_r[3];
      out_data_r.out_quat_x   <= res_r[4];
      out_data_r.out_quat_y   <= res_r[5];
      out_data_r.out_quat_z   <= res_r[6];
      out_data_r.out_move_x   <= res_r[7];
      out_data_r.out_move_y   <= res_r[8];
      out_data_r.out_move_z   <= res_r[9];
      out_data_r.last_of_run  <= frame_end && !later_ne;
      i_r    <= i_r + SEG_W'(1);
      step_r <= 3'd0;
      u_r    <= u_r + q_r + 17'(ur_ge);
      ur_r   <= ur_ge ? 16'(ur_sum - 17'(g_r)) : ur_sum[15:0];
    end

    // Next segment.
    if (state_r == ST_SEG_NEXT) begin
      seg_r    <= seg_r + 3'd1;
      ld_cnt_r <= 2'd0;
    end

    // Slide the window once it is full.
    if (state_r == ST_END && !fin_r && w_r == 2'd3) begin
      seq_r[0] <= seq_r[1];
      seq_r[1] <= seq_r[2];
      seq_r[2] <= seq_r[3];
    end
  end

endmodule

// ===== rtl/crk_checker.sv =====
`timescale 1ns / 1ps

module crk_checker import crk_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input frame_out_t out_data
);

  // A keyframe transfer makes the block busy on the next cycle.
  a_busy_after_key: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after a keyframe transfer");

  // A pending frame that is not the last one means more frames follow.
  a_no_ready_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last_of_run) |-> !in_ready)
    else $error("input ready while a run is still open");

  // Reset empties the output register.
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A stalled frame holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled frame changed");

endmodule

bind catmull_rom_keyframe_interp crk_checker u_crk_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_key.valid),
  .in_ready  (in_key.ready),
  .out_valid (out_frame.valid),
  .out_ready (out_frame.ready),
  .out_data  (out_frame.data)
);

// ===== bench/catmull_rom_keyframe_interp_tb.sv =====
`timescale 1ns / 1ps

module catmull_rom_keyframe_interp_tb;
  import crk_pkg::*;

  localparam int  IDLE_WAIT   = 3000;
  localparam int  CYCLE_LIMIT = 20000000;
  localparam int  HOLD_CYCLES = 4000;
  localparam int  NO_CFG      = -1;
  localparam int  NO_COUNT    = -1;

  // One keyframe kept by the predictor, channels at full precision.
  typedef struct {
    int unsigned frame;
    longint      ch[NCH];
  } key_state_t;

  // One row of the directed stimulus.
  typedef struct {
    int      cfg_val;
    key_in_t key;
    int      frames_hand;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  crk_key_if   key_if ();
  crk_frame_if frm_if ();

  catmull_rom_keyframe_interp u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_key    (key_if.sink),
    .out_frame (frm_if.source),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state and the frames it still expects.
  key_state_t  win[3];
  int unsigned win_count;
  int unsigned total_frames_q;
  frame_out_t  frames_due[$];

  int errors;
  int frames_seen;
  int keys_sent;
  int cfg_writes;
  int cycles;
  bit hold_go;
  bit hold_done;
  int hold_cnt;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d frames still due", cycles, frames_due.size());
      $display("** catmull_rom_keyframe_interp: FAILED **");
      $finish;
    end
  end

  function automatic key_state_t to_state(key_in_t k);
    key_state_t s;
    s.frame = k.key_frame;
    s.ch[0] = k.scale_x;
    s.ch[1] = k.scale_y;
    s.ch[2] = k.scale_z;
    s.ch[3] = k.quat_w;
    s.ch[4] = k.quat_x;
    s.ch[5] = k.quat_y;
    s.ch[6] = k.quat_z;
    s.ch[7] = k.move_x;
    s.ch[8] = k.move_y;
    s.ch[9] = k.move_z;
    return s;
  endfunction

  // Hermite frames for the segment b..c with outer neighbors a and d.
  function automatic int hermite_segment(key_state_t a, key_state_t b, key_state_t c,
                                         key_state_t d);
    longint g, n, uq, u2, u3, s3, n00, n01, n10, n11, h00, h01, h10, h11, sum, r;
    longint hi, lo;
    logic [PORT_W-1:0] vals[NCH];
    frame_out_t f;
    int cnt;
    cnt = 0;
    hi = (64'sd1 <<< (CHANNEL_BITS - 1)) - 1;
    lo = -hi - 1;
    s3 = 64'sd1 <<< 48;
    g = longint'(c.frame) - longint'(b.frame);
    n = (g > MAX_SEG) ? MAX_SEG : g;
    for (longint i = 0; i < n; i++) begin
      uq  = (i * 65536) / g;
      u2  = uq * uq;
      u3  = u2 * uq;
      n00 = 2 * u3 - 3 * u2 * 65536 + s3;
      n01 = s3 - n00;
      n10 = uq * (65536 - uq) * (65536 - uq);
      n11 = u2 * (65536 - uq);
      h00 = (n00 + (64'sd1 <<< 31)) >>> 32;
      h01 = (n01 + (64'sd1 <<< 31)) >>> 32;
      h10 = (n10 + (64'sd1 <<< 31)) >>> 32;
      h11 = (n11 + (64'sd1 <<< 31)) >>> 32;
      for (int j = 0; j < NCH; j++) begin
        sum = 2 * h00 * b.ch[j] + 2 * h01 * c.ch[j] + h10 * (c.ch[j] - a.ch[j])
            - h11 * (d.ch[j] - b.ch[j]);
        r = (sum + (64'sd1 <<< 16)) >>> 17;
        if (r > hi) r = hi;
        if (r < lo) r = lo;
        vals[j] = r[PORT_W-1:0];
      end
      f.frame_number = 16'(b.frame + i);
      f.out_scale_x  = vals[0];
      f.out_scale_y  = vals[1];
      f.out_scale_z  = vals[2];
      f.out_quat_w   = vals[3];
      f.out_quat_x   = vals[4];
      f.out_quat_y   = vals[5];
      f.out_quat_z   = vals[6];
      f.out_move_x   = vals[7];
      f.out_move_y   = vals[8];
      f.out_move_z   = vals[9];
      f.last_of_run  = 1'b0;
      frames_due = {frames_due, f};
      cnt++;
    end
    return cnt;
  endfunction

  // Advances the key window by one keyframe and queues the frames it causes.
  function automatic int predict_frames(key_in_t k);
    key_state_t seq[5];
    int w, m, mnf, first, last, i0, i3, cnt;
    cnt = 0;
    w = win_count;
    for (int i = 0; i < w; i++) seq[i] = win[i];
    seq[w] = to_state(k);
    mnf = w + 1;
    m = mnf;
    if (k.is_final) begin
      seq[m] = seq[mnf - 1];
      seq[m].frame = total_frames_q;
      m++;
      first = (mnf - 3 < 0) ? 0 : mnf - 3;
      last  = mnf - 1;
    end else begin
      first = mnf - 3;
      last  = mnf - 3;
    end
    if (first >= 0) begin
      for (int s = first; s <= last; s++) begin
        i0 = (s - 1 < 0) ? 0 : s - 1;
        i3 = (s + 2 > m - 1) ? m - 1 : s + 2;
        cnt += hermite_segment(seq[i0], seq[s], seq[s + 1], seq[i3]);
      end
    end
    if (k.is_final) begin
      win_count = 0;
    end else if (w == 3) begin
      win[0] = seq[1];
      win[1] = seq[2];
      win[2] = seq[3];
    end else begin
      win[w] = seq[w];
      win_count = w + 1;
    end
    if (cnt > 0) frames_due[$].last_of_run = 1'b1;
    return cnt;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
    errors++;
  endtask

  // Result side: compare each transfer, then pick the next ready level.
  always @(posedge clk) begin
    frame_out_t got, want;
    if (!rst_n) begin
      frm_if.ready <= 1'b0;
    end else begin
      if (frm_if.valid && frm_if.ready) begin
        got = frm_if.data;
        frames_seen++;
        if (frames_due.size() == 0) begin
          report("unexpected frame", got.frame_number, 0);
        end else begin
          want = frames_due.pop_front();
          if (got.frame_number != want.frame_number)
            report("frame_number", got.frame_number, want.frame_number);
          if (got.out_scale_x != want.out_scale_x)
            report("out_scale_x", got.out_scale_x, want.out_scale_x);
          if (got.out_scale_y != want.out_scale_y)
            report("out_scale_y", got.out_scale_y, want.out_scale_y);
          if (got.out_scale_z != want.out_scale_z)
            report("out_scale_z", got.out_scale_z, want.out_scale_z);
          if (got.out_quat_w != want.out_quat_w)
            report("out_quat_w", got.out_quat_w, want.out_quat_w);
          if (got.out_quat_x != want.out_quat_x)
            report("out_quat_x", got.out_quat_x, want.out_quat_x);
          if (got.out_quat_y != want.out_quat_y)
            report("out_quat_y", got.out_quat_y, want.out_quat_y);
          if (got.out_quat_z != want.out_quat_z)
            report("out_quat_z", got.out_quat_z, want.out_quat_z);
          if (got.out_move_x != want.out_move_x)
            report("out_move_x", got.out_move_x, want.out_move_x);
          if (got.out_move_y != want.out_move_y)
            report("out_move_y", got.out_move_y, want.out_move_y);
          if (got.out_move_z != want.out_move_z)
            report("out_move_z", got.out_move_z, want.out_move_z);
          if (got.last_of_run != want.last_of_run)
            report("last_of_run", got.last_of_run, want.last_of_run);
        end
      end
      if (hold_go && !hold_done) begin
        // Long hold-off so the block fills up and stalls its input.
        frm_if.ready <= 1'b0;
        hold_cnt++;
        if (hold_cnt >= HOLD_CYCLES) hold_done = 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        frm_if.ready <= 1'b1;
      end else if ($urandom_range(0, 40) == 0) begin
        frm_if.ready <= 1'b0;
        hold_cnt = 0;
      end else begin
        frm_if.ready <= ($urandom_range(0, 2) != 0);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(5, 60);
  endfunction

  // Offers one keyframe and returns after its transfer plus a random gap.
  task automatic send_key(key_in_t k, output int caused);
    int gap;
    key_if.valid <= 1'b1;
    key_if.data  <= k;
    do @(posedge clk); while (!key_if.ready);
    caused = predict_frames(k);
    keys_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      key_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Writes total_frames once every frame is out and the block is idle.
  task automatic write_total(int unsigned v);
    key_if.valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    total_frames_q = v[15:0];
    cfg_writes++;
  endtask

  function automatic logic [PORT_W-1:0] rand_channel();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return {1'b0, {(PORT_W-1){1'b1}}};
    if (r == 1) return {1'b1, {(PORT_W-1){1'b0}}};
    if (r < 5) return PORT_W'($signed($urandom_range(0, 131072)) - 65536);
    return PORT_W'($urandom);
  endfunction

  function automatic key_in_t rand_key(int unsigned frame, bit fin);
    key_in_t k;
    k.key_frame = frame[15:0];
    k.scale_x = rand_channel();
    k.scale_y = rand_channel();
    k.scale_z = rand_channel();
    k.quat_w  = rand_channel();
    k.quat_x  = rand_channel();
    k.quat_y  = rand_channel();
    k.quat_z  = rand_channel();
    k.move_x  = rand_channel();
    k.move_y  = rand_channel();
    k.move_z  = rand_channel();
    k.is_final = fin;
    return k;
  endfunction

  function automatic key_in_t flat_key(int unsigned frame, logic [PORT_W-1:0] v, bit fin);
    key_in_t k;
    k = rand_key(frame, fin);
    {k.scale_x, k.scale_y, k.scale_z, k.quat_w, k.quat_x} = {5{v}};
    {k.quat_y, k.quat_z, k.move_x, k.move_y, k.move_z}   = {5{v}};
    return k;
  endfunction

  function automatic stim_row_t row(int cv, key_in_t k, int hand);
    stim_row_t r;
    r.cfg_val = cv;
    r.key = k;
    r.frames_hand = hand;
    return r;
  endfunction

  // Main sequence: directed table, then random keyframe sequences.
  initial begin
    stim_row_t   tbl[$];
    int          caused, seq_len, step, phase;
    int unsigned frame;
    logic [PORT_W-1:0] pmax, pmin;
    pmax = {1'b0, {(PORT_W-1){1'b1}}};
    pmin = {1'b1, {(PORT_W-1){1'b0}}};
    errors = 0;
    frames_seen = 0;
    keys_sent = 0;
    cfg_writes = 0;
    cycles = 0;
    hold_go = 0;
    hold_done = 0;
    hold_cnt = 0;
    win_count = 0;
    total_frames_q = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    key_if.valid = 1'b0;
    key_if.data = '0;
    frm_if.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A lone final key right after reset: total_frames is zero, so no gap.
    tbl = {tbl, row(NO_CFG, flat_key(0, 0, 1), 0)};
    // A normal run with extreme channels, a zero gap and a truncated gap.
    tbl = {tbl, row(12, flat_key(0, pmax, 0), 0)};
    tbl = {tbl, row(NO_CFG, flat_key(3, pmin, 0), 0)};
    tbl = {tbl, row(NO_CFG, flat_key(5, pmax, 0), NO_COUNT)};
    tbl = {tbl, row(NO_CFG, flat_key(6, pmin, 0), NO_COUNT)};
    tbl = {tbl, row(NO_CFG, rand_key(6, 0), NO_COUNT)};
    tbl = {tbl, row(NO_CFG, rand_key(40, 0), NO_COUNT)};
    tbl = {tbl, row(NO_CFG, rand_key(41, 1), NO_COUNT)};
    // Last frame number with total_frames at its top: nothing to emit.
    tbl = {tbl, row(65535, flat_key(65535, pmax, 1), 0)};
    // Appended copy far away: truncated to the segment limit.
    tbl = {tbl, row(NO_CFG, flat_key(100, pmin, 1), MAX_SEG)};
    // Two keys then flush with total_frames below the last key.
    tbl = {tbl, row(0, rand_key(10, 0), 0)};
    tbl = {tbl, row(NO_CFG, rand_key(20, 1), 10)};
    // Decreasing and equal frame numbers inside a run.
    tbl = {tbl, row(30, rand_key(20, 0), 0)};
    tbl = {tbl, row(NO_CFG, rand_key(10, 0), 0)};
    tbl = {tbl, row(NO_CFG, rand_key(10, 0), NO_COUNT)};
    tbl = {tbl, row(NO_CFG, rand_key(14, 0), NO_COUNT)};
    tbl = {tbl, row(NO_CFG, rand_key(14, 1), NO_COUNT)};
    // Frame numbers at the top of the 16-bit range.
    tbl = {tbl, row(65535, rand_key(65530, 0), 0)};
    tbl = {tbl, row(NO_CFG, rand_key(65534, 0), 0)};
    tbl = {tbl, row(NO_CFG, rand_key(65535, 1), NO_COUNT)};
    foreach (tbl[i]) begin
      if (tbl[i].cfg_val != NO_CFG) write_total(tbl[i].cfg_val);
      send_key(tbl[i].key, caused);
      if (tbl[i].frames_hand != NO_COUNT && caused != tbl[i].frames_hand)
        report("frames for directed row", caused, tbl[i].frames_hand);
    end

    // Random runs, mostly well-formed, with a few broken ones.
    phase = 0;
    while (keys_sent < 470) begin
      if (phase % 8 == 0) begin
        case ($urandom_range(0, 3))
          0: write_total(0);
          1: write_total(65535);
          default: write_total($urandom_range(0, 65535));
        endcase
      end
      if (phase == 3) hold_go = 1'b1;
      frame = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 200);
      seq_len = $urandom_range(1, 9);
      for (step = 0; step < seq_len; step++) begin
        send_key(rand_key(frame, step == seq_len - 1), caused);
        case ($urandom_range(0, 19))
          0: frame = frame - $urandom_range(1, 8);
          1: frame = frame;
          2: frame = frame + $urandom_range(MAX_SEG + 1, 60);
          default: frame = frame + $urandom_range(1, 8);
        endcase
      end
      // Occasionally a total_frames value at or just past the run's end.
      if (phase % 8 == 5) write_total(16'(frame + $urandom_range(0, 4)));
      phase++;
    end

    key_if.valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
    $display("covered %0d keyframes, %0d generated frames, %0d total_frames writes",
             keys_sent, frames_seen, cfg_writes);
    $display("directed extremes, zero and long gaps, wraps, flushes and a long output stall");
    if (errors == 0 && frames_due.size() == 0) begin
      $display("** catmull_rom_keyframe_interp: PASSED **");
    end else begin
      $display("%0d mismatches, %0d frames never seen", errors, frames_due.size());
      $display("** catmull_rom_keyframe_interp: FAILED **");
    end
    $finish;
  end

endmodule
